// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers: every check is sampled on clk and muted while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds whenever the antecedent holds.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/stbt_pkg.sv -----
package stbt_pkg;

    localparam int COUNT_W = 32;
    localparam int DENS_W  = 16;
    localparam int ID_W    = 4;
    localparam int NUM_W   = 5;

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_CLASSIFY = 2'd1,
        ACT_READ     = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_FULL          = 3'd1,
        ST_FIRST_NONZERO = 3'd2,
        ST_EMPTY         = 3'd3,
        ST_RANGE         = 3'd4
    } status_t;

    // Per-cell command, common to every cell of the row
    typedef struct packed {
        logic            by_pos;  // compare cell position instead of threshold
        logic            ins_en;  // commit an insert this cycle
        logic [ID_W-1:0] pos;
    } cell_ctl_t;

    // Per-cell compare result, handed to the neighbour and the selector
    typedef struct packed {
        logic le;  // occupied and at or below the key
        logic gt;  // occupied and above the key
    } cell_flags_t;

endpackage

// ----- hw/rtl/stbt_req_if.sv -----
interface stbt_req_if;
    import stbt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [COUNT_W-1:0]   count_value;
    logic [DENS_W-1:0]    density_value;
    logic [ID_W-1:0]      entry_index;

    modport source (
        output valid, action, count_value, density_value, entry_index,
        input  ready
    );

    modport sink (
        input  valid, action, count_value, density_value, entry_index,
        output ready
    );
endinterface

// ----- hw/rtl/stbt_rsp_if.sv -----
interface stbt_rsp_if;
    import stbt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [ID_W-1:0]      bucket_id;
    logic [COUNT_W-1:0]   range_low;
    logic [COUNT_W-1:0]   range_high;
    logic [DENS_W-1:0]    entry_density;
    logic [NUM_W-1:0]     entry_count;

    modport source (
        output valid, status, bucket_id, range_low, range_high, entry_density, entry_count,
        input  ready
    );

    modport sink (
        input  valid, status, bucket_id, range_low, range_high, entry_density, entry_count,
        output ready
    );
endinterface

// ----- hw/rtl/stbt_cell.sv -----
module stbt_cell #(
    parameter int IDX = 0,
    parameter int TW  = 32,
    parameter int CW  = 5
) (
    input  logic                          clk,
    input  stbt_pkg::cell_ctl_t           ctl,
    input  logic [CW-1:0]                 fill,
    input  logic [TW-1:0]                 key,
    input  logic [stbt_pkg::DENS_W-1:0]   dens_in,
    input  stbt_pkg::cell_flags_t         left_flags,
    input  logic [TW-1:0]                 left_thr,
    input  logic [stbt_pkg::DENS_W-1:0]   left_dens,
    output stbt_pkg::cell_flags_t         flags,
    output logic [TW-1:0]                 thr,
    output logic [stbt_pkg::DENS_W-1:0]   dens
);
    import stbt_pkg::*;

    logic              thr_en;
    logic [TW-1:0]     thr_reg;
    logic [TW-1:0]     thr_next;
    logic [DENS_W-1:0] dens_reg;
    logic [DENS_W-1:0] dens_next;
    logic              occupied;
    logic              at_or_below;

    assign occupied = 32'(fill) > 32'(IDX);

    always_comb
    begin
        if (ctl.by_pos)
        begin
            at_or_below = 32'(IDX) <= 32'(ctl.pos);
        end
        else
        begin
            at_or_below = thr_reg <= key;
        end
        flags.le = occupied && at_or_below;
        flags.gt = occupied && !at_or_below;

        // Load if above key or first free: the left entry if above, else the new one
        thr_en = ctl.ins_en && (flags.gt || (32'(fill) == 32'(IDX)));
        if (left_flags.gt)
        begin
            thr_next  = left_thr;
            dens_next = left_dens;
        end
        else
        begin
            thr_next  = key;
            dens_next = dens_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (thr_en)
        begin
            thr_reg  <= thr_next;
            dens_reg <= dens_next;
        end
    end

    assign thr  = thr_reg;
    assign dens = dens_reg;

endmodule

// ----- hw/rtl/stbt_pick.sv -----
module stbt_pick #(
    parameter int N  = 16,
    parameter int TW = 32,
    parameter int IW = 4
) (
    input  stbt_pkg::cell_flags_t         flags [N],
    input  logic [TW-1:0]                 thr   [N],
    input  logic [stbt_pkg::DENS_W-1:0]   dens  [N],
    output logic                          hit,
    output logic [IW-1:0]                 hit_idx,
    output logic [TW-1:0]                 hit_thr,
    output logic [stbt_pkg::DENS_W-1:0]   hit_dens,
    output logic                          next_any,
    output logic [TW-1:0]                 next_thr
);
    import stbt_pkg::*;

    logic [N:0]   le_v;
    logic [N:0]   gt_v;
    logic [N-1:0] bnd;
    logic [N-1:0] fst;

    assign le_v[N] = 1'b0;
    assign gt_v[0] = 1'b0;

    for (genvar g = 0; g < N; g++)
    begin : g_flags
        assign le_v[g]   = flags[g].le;
        assign gt_v[g+1] = flags[g].gt;
        // Last cell at or below the key, and first cell above it
        assign bnd[g] = le_v[g] && !le_v[g+1];
        assign fst[g] = gt_v[g+1] && !gt_v[g];
    end

    always_comb
    begin
        hit      = |bnd;
        next_any = |fst;
        hit_idx  = '0;
        hit_thr  = '0;
        hit_dens = '0;
        next_thr = '0;
        for (int i = 0; i < N; i++)
        begin
            hit_idx  = hit_idx  | (bnd[i] ? IW'(i) : '0);
            hit_thr  = hit_thr  | (bnd[i] ? thr[i] : '0);
            hit_dens = hit_dens | (bnd[i] ? dens[i] : '0);
            next_thr = next_thr | (fst[i] ? thr[i] : '0);
        end
    end

endmodule

// ----- hw/rtl/sorted_threshold_bucket_table_top.sv -----
// Sorted threshold bucket table. A row of MAX_ENTRIES cells holds (threshold, density)
// entries in ascending threshold order; the fill count and the response valid flag are
// the only state that reset clears, and a cell's contents count only while its position
// is below the fill count, so no clearing pass follows reset. Every request transaction
// is answered by exactly one response transaction. Insert (action 0) compares the key
// against every cell at once; cells above the key shift one place up and the first free
// or vacated cell takes the new entry, after any equal thresholds. The first entry must
// have threshold zero and a full table refuses the insert; both leave the table as it
// was. Classify (action 1) returns the last bucket whose threshold is at most the count,
// with its bounds and density; read (action 2) returns the entry at entry_index. The
// upper bound of the last bucket is TW ones (COUNT_BITS capped at COUNT_W). Only the
// low COUNT_BITS bits of count_value are used. Each request is accepted, the whole row
// compares and updates in that same cycle, and the response is registered for the next.
// The rate is one transaction per cycle, set by the single compare-and-select across
// the cell row; a new request is taken while a response waits as long as that response
// is being taken in the same cycle.
module sorted_threshold_bucket_table_top #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    stbt_req_if.sink    req,
    stbt_rsp_if.source  rsp
);
    import stbt_pkg::*;

    `include "assert_macros.svh"

    // Threshold width held in the cells, index width and fill count width
    localparam int TW = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [COUNT_W-1:0] TOP_BOUND = COUNT_W'((64'(1) << TW) - 64'(1));

    // Handshake and fill count
    logic          accept;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;

    // Request decode
    action_t       act;
    logic [TW-1:0] key;
    logic          full;
    logic          empty;
    logic          ins_ok;
    cell_ctl_t     ctl;

    // Cell row
    cell_flags_t       cell_flags [MAX_ENTRIES];
    logic [TW-1:0]     cell_thr   [MAX_ENTRIES];
    logic [DENS_W-1:0] cell_dens  [MAX_ENTRIES];

    // Selector results
    logic              hit;
    logic [IW-1:0]     hit_idx;
    logic [TW-1:0]     hit_thr;
    logic [DENS_W-1:0] hit_dens;
    logic              next_any;
    logic [TW-1:0]     next_thr;
    logic [COUNT_W-1:0] upper;

    // Response register
    status_t            status_reg,  status_next;
    logic [ID_W-1:0]    id_reg,      id_next;
    logic [COUNT_W-1:0] low_reg,     low_next;
    logic [COUNT_W-1:0] high_reg,    high_next;
    logic [DENS_W-1:0]  dens_reg,    dens_next;
    logic [NUM_W-1:0]   num_reg,     num_next;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign act   = action_t'(req.action);
    assign key   = req.count_value[TW-1:0];
    assign full  = fill_reg == CW'(MAX_ENTRIES);
    assign empty = fill_reg == '0;

    // Insert goes ahead only into a non-full table, and the first key must be zero
    assign ins_ok = (act == ACT_INSERT) && !full && !(empty && (key != '0));

    always_comb
    begin
        ctl.by_pos = act == ACT_READ;
        ctl.ins_en = accept && ins_ok;
        ctl.pos    = req.entry_index;
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        cell_flags_t       left_flags;
        logic [TW-1:0]     left_thr;
        logic [DENS_W-1:0] left_dens;

        if (g == 0)
        begin : g_head
            assign left_flags = '0;
            assign left_thr   = '0;
            assign left_dens  = '0;
        end
        else
        begin : g_link
            assign left_flags = cell_flags[g-1];
            assign left_thr   = cell_thr[g-1];
            assign left_dens  = cell_dens[g-1];
        end

        stbt_cell #(
            .IDX (g),
            .TW  (TW),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .fill       (fill_reg),
            .key        (key),
            .dens_in    (req.density_value),
            .left_flags (left_flags),
            .left_thr   (left_thr),
            .left_dens  (left_dens),
            .flags      (cell_flags[g]),
            .thr        (cell_thr[g]),
            .dens       (cell_dens[g])
        );
    end

    stbt_pick #(
        .N  (MAX_ENTRIES),
        .TW (TW),
        .IW (IW)
    ) u_pick (
        .flags    (cell_flags),
        .thr      (cell_thr),
        .dens     (cell_dens),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .hit_thr  (hit_thr),
        .hit_dens (hit_dens),
        .next_any (next_any),
        .next_thr (next_thr)
    );

    // Upper bound: the first threshold above the key, or all ones past the last bucket
    assign upper = next_any ? COUNT_W'(next_thr) : TOP_BOUND;

    always_comb
    begin
        status_next = ST_OK;
        id_next     = '0;
        low_next    = '0;
        high_next   = '0;
        dens_next   = '0;
        fill_next   = ins_ok ? CW'(fill_reg + 1'b1) : fill_reg;
        case (act)
            ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (!ins_ok)
                begin
                    status_next = ST_FIRST_NONZERO;
                end
                else
                begin
                    // New entry lands just past the last threshold at or below it
                    id_next   = empty ? '0 : ID_W'(IW'(hit_idx + IW'(1)));
                    low_next  = COUNT_W'(key);
                    high_next = upper;
                    dens_next = req.density_value;
                end
            end
            ACT_CLASSIFY:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    id_next   = ID_W'(hit_idx);
                    low_next  = COUNT_W'(hit_thr);
                    high_next = upper;
                    dens_next = hit_dens;
                end
            end
            ACT_READ:
            begin
                if (32'(req.entry_index) >= 32'(fill_reg) || !hit)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    id_next   = ID_W'(hit_idx);
                    low_next  = COUNT_W'(hit_thr);
                    high_next = upper;
                    dens_next = hit_dens;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        num_next = NUM_W'(fill_next);
    end

    // Hold the response until taken; a new transaction may replace it in the same cycle
    assign rsp_valid_next = accept ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            id_reg     <= id_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            dens_reg   <= dens_next;
            num_reg    <= num_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.bucket_id     = id_reg;
    assign rsp.range_low     = low_reg;
    assign rsp.range_high    = high_reg;
    assign rsp.entry_density = dens_reg;
    assign rsp.entry_count   = num_reg;

    `ASSERT_ALWAYS(a_fill_bound, fill_reg <= CW'(MAX_ENTRIES), "fill count beyond table size")
    `ASSERT_IMPLY(a_fill_step, fill_reg != $past(fill_reg),
        $past(accept) && (fill_reg == CW'($past(fill_reg) + 1'b1)),
        "fill count moved other than by one accepted insert")
    `ASSERT_IMPLY(a_head_zero, fill_reg != '0, cell_thr[0] == '0,
        "first bucket threshold is not zero")
    `ASSERT_IMPLY(a_rsp_order, rsp_valid_reg && (status_reg == ST_OK), low_reg <= high_reg,
        "response bucket bounds out of order")
    `ASSERT_IMPLY(a_no_overrun, rsp_valid_reg && !rsp.ready, !accept,
        "request taken while response stalled")

endmodule
